// File: design/bu_pkg.sv
`default_nettype none

package bu_pkg;

	// configuration and field widths
	localparam int SRC_DIM_BITS  = 13;
	localparam int TGT_DIM_BITS  = 11;
	localparam int POS_BITS      = 10;
	localparam int IDX_BITS      = 12;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 13;

	// defaults for the top level parameters
	localparam int DEF_SOURCE_SAMPLES = 4096;
	localparam int DEF_SAMPLE_BITS    = 16;

	// fixed point
	localparam int FRAC_BITS = 8;
	localparam int WGT_BITS  = FRAC_BITS + 1;
	localparam int WPROD_BITS = 2 * FRAC_BITS + 1;

	// position mapping: (2*pos+1)*in_len fits in NUM_BITS
	localparam int NUM_BITS  = POS_BITS + 1 + SRC_DIM_BITS;
	localparam int DEN_BITS  = TGT_DIM_BITS + 1;
	localparam int DIV_STEPS = (NUM_BITS + FRAC_BITS + 1) / 2;
	localparam int DVD_BITS  = 2 * DIV_STEPS;
	localparam int QINT_BITS = DVD_BITS - FRAC_BITS;
	localparam int CNT_BITS  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam int LIN_BITS  = 2 * SRC_DIM_BITS + 1;

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_HEIGHT = 2'd3;

	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_MUL,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_END,
		OP_TAP_ADDR,
		OP_TAP_READ,
		OP_TAP_PROD,
		OP_TAP_ACC,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		logic        load;
		dp_op_t      op;
		logic        axis;
		logic [1:0]  tap;
	} dp_cmd_t;

endpackage

`default_nettype wire

// File: design/bu_datapath.sv
`default_nettype none

module bu_datapath #(
	parameter int MAX_SOURCE_SAMPLES = bu_pkg::DEF_SOURCE_SAMPLES,
	parameter int SAMPLE_BITS        = bu_pkg::DEF_SAMPLE_BITS
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  bu_pkg::dp_cmd_t                   ctl,
	input  wire                               cmd,
	input  wire [bu_pkg::IDX_BITS-1:0]        sample_index,
	input  wire [SAMPLE_BITS-1:0]             sample_value,
	input  wire [bu_pkg::POS_BITS-1:0]        target_x,
	input  wire [bu_pkg::POS_BITS-1:0]        target_y,
	input  wire                               cfg_we,
	input  wire [bu_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire [bu_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output logic [SAMPLE_BITS-1:0]            pixel_value,
	output logic [bu_pkg::POS_BITS-1:0]       pixel_x,
	output logic [bu_pkg::POS_BITS-1:0]       pixel_y
);
	import bu_pkg::*;

	localparam int AW        = (MAX_SOURCE_SAMPLES > 1) ? $clog2(MAX_SOURCE_SAMPLES) : 1;
	localparam int PROD_BITS = SAMPLE_BITS + WPROD_BITS;
	localparam int ACC_BITS  = SAMPLE_BITS + 2 * FRAC_BITS + 1;
	localparam logic [LIN_BITS-1:0] LIN_LAST = LIN_BITS'(MAX_SOURCE_SAMPLES - 1);
	localparam logic [WGT_BITS-1:0] ONE_FRAC = WGT_BITS'(1) << FRAC_BITS;

	logic [SAMPLE_BITS-1:0] mem [MAX_SOURCE_SAMPLES];

	logic [SRC_DIM_BITS-1:0] src_w_q, src_h_q;
	logic [TGT_DIM_BITS-1:0] tgt_w_q, tgt_h_q;
	logic [POS_BITS-1:0]     tx_q, ty_q;
	logic [NUM_BITS-1:0]     num_q;
	logic [DVD_BITS-1:0]     dvd_q, quo_q;
	logic [DEN_BITS-1:0]     rem_q, den_q;
	logic [SRC_DIM_BITS-1:0] x0_q, y0_q;
	logic [FRAC_BITS-1:0]    fx_q, fy_q;
	logic [LIN_BITS-1:0]     lin_q;
	logic [WPROD_BITS-1:0]   wt_q;
	logic [SAMPLE_BITS-1:0]  rd_q;
	logic [PROD_BITS-1:0]    prod_q;
	logic [ACC_BITS-1:0]     acc_q;
	logic [SAMPLE_BITS-1:0]  pixel_value_q;
	logic [POS_BITS-1:0]     pixel_x_q, pixel_y_q;

	logic [SRC_DIM_BITS-1:0] in_w, in_h, in_len, lim;
	logic [TGT_DIM_BITS-1:0] out_w, out_h, out_len;
	logic [POS_BITS-1:0]     pos;
	logic [NUM_BITS-1:0]     n_start;
	logic [DEN_BITS:0]       t1, t2;
	logic                    ge1, ge2;
	logic [DEN_BITS-1:0]     r1, r2;
	logic [QINT_BITS-1:0]    q_int;
	logic [SRC_DIM_BITS-1:0] x1, y1, row, col;
	logic [WGT_BITS-1:0]     wx, wy;
	logic [LIN_BITS-1:0]     rd_lin;
	logic [AW-1:0]           rd_addr, wr_addr;
	logic                    wr_en;

	// a dimension register holding zero acts as one
	assign in_w  = (src_w_q == '0) ? SRC_DIM_BITS'(1) : src_w_q;
	assign in_h  = (src_h_q == '0) ? SRC_DIM_BITS'(1) : src_h_q;
	assign out_w = (tgt_w_q == '0) ? TGT_DIM_BITS'(1) : tgt_w_q;
	assign out_h = (tgt_h_q == '0) ? TGT_DIM_BITS'(1) : tgt_h_q;

	assign in_len  = (ctl.axis == AXIS_Y) ? in_h : in_w;
	assign out_len = (ctl.axis == AXIS_Y) ? out_h : out_w;
	assign pos     = (ctl.axis == AXIS_Y) ? ty_q : tx_q;
	assign lim     = in_len - SRC_DIM_BITS'(1);

	// left edge: a non-positive numerator divides to zero
	assign n_start = (num_q > NUM_BITS'(out_len)) ? num_q - NUM_BITS'(out_len) : '0;

	// two restoring steps per cycle
	always_comb begin
		t1  = {rem_q, dvd_q[DVD_BITS-1]};
		ge1 = t1 >= {1'b0, den_q};
		r1  = ge1 ? DEN_BITS'(t1 - {1'b0, den_q}) : DEN_BITS'(t1);
		t2  = {r1, dvd_q[DVD_BITS-2]};
		ge2 = t2 >= {1'b0, den_q};
		r2  = ge2 ? DEN_BITS'(t2 - {1'b0, den_q}) : DEN_BITS'(t2);
	end

	assign q_int = quo_q[DVD_BITS-1:FRAC_BITS];

	assign x1 = (({1'b0, x0_q} + 1'b1) < {1'b0, in_w}) ? x0_q + 1'b1 : in_w - 1'b1;
	assign y1 = (({1'b0, y0_q} + 1'b1) < {1'b0, in_h}) ? y0_q + 1'b1 : in_h - 1'b1;
	assign row = ctl.tap[1] ? y1 : y0_q;
	assign col = ctl.tap[0] ? x1 : x0_q;
	assign wx  = ctl.tap[0] ? {1'b0, fx_q} : ONE_FRAC - {1'b0, fx_q};
	assign wy  = ctl.tap[1] ? {1'b0, fy_q} : ONE_FRAC - {1'b0, fy_q};

	// reads beyond the store saturate to its last entry
	assign rd_lin  = (lin_q > LIN_LAST) ? LIN_LAST : lin_q;
	assign rd_addr = AW'(rd_lin);
	assign wr_addr = AW'(sample_index);
	assign wr_en   = ctl.load && (cmd == CMD_WRITE) &&
		(32'(sample_index) < 32'(MAX_SOURCE_SAMPLES));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= sample_value;
		end
		if (ctl.op == OP_TAP_READ) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SRC_DIM_BITS'(1);
			src_h_q <= SRC_DIM_BITS'(1);
			tgt_w_q <= TGT_DIM_BITS'(1);
			tgt_h_q <= TGT_DIM_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_WIDTH:  src_w_q <= cfg_data;
				REG_SOURCE_HEIGHT: src_h_q <= cfg_data;
				REG_TARGET_WIDTH:  tgt_w_q <= cfg_data[TGT_DIM_BITS-1:0];
				REG_TARGET_HEIGHT: tgt_h_q <= cfg_data[TGT_DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			tx_q <= target_x;
			ty_q <= target_y;
		end
		case (ctl.op)
			OP_MUL: begin
				num_q <= NUM_BITS'({pos, 1'b1}) * NUM_BITS'(in_len);
			end
			OP_DIV_INIT: begin
				dvd_q <= DVD_BITS'({n_start, {FRAC_BITS{1'b0}}});
				den_q <= {out_len, 1'b0};
				rem_q <= '0;
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= r2;
				dvd_q <= {dvd_q[DVD_BITS-3:0], 2'b00};
				quo_q <= {quo_q[DVD_BITS-3:0], ge1, ge2};
			end
			OP_DIV_END: begin
				// right or bottom edge clamps with zero fraction
				if (ctl.axis == AXIS_Y) begin
					if (q_int >= QINT_BITS'(lim)) begin
						y0_q <= lim;
						fy_q <= '0;
					end else begin
						y0_q <= SRC_DIM_BITS'(q_int);
						fy_q <= quo_q[FRAC_BITS-1:0];
					end
				end else begin
					if (q_int >= QINT_BITS'(lim)) begin
						x0_q <= lim;
						fx_q <= '0;
					end else begin
						x0_q <= SRC_DIM_BITS'(q_int);
						fx_q <= quo_q[FRAC_BITS-1:0];
					end
				end
			end
			OP_TAP_ADDR: begin
				lin_q <= LIN_BITS'(row) * LIN_BITS'(in_w) + LIN_BITS'(col);
				wt_q  <= WPROD_BITS'(wx) * WPROD_BITS'(wy);
			end
			OP_TAP_PROD: begin
				prod_q <= PROD_BITS'(rd_q) * PROD_BITS'(wt_q);
			end
			OP_TAP_ACC: begin
				acc_q <= ((ctl.tap == 2'd0) ? '0 : acc_q) + ACC_BITS'(prod_q);
			end
			OP_OUT: begin
				pixel_value_q <= acc_q[2*FRAC_BITS +: SAMPLE_BITS];
				pixel_x_q     <= tx_q;
				pixel_y_q     <= ty_q;
			end
			default: ;
		endcase
	end

	assign pixel_value = pixel_value_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;

endmodule

`default_nettype wire

// File: design/bu_ctrl.sv
`default_nettype none

module bu_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  wire             cmd,
	output logic            out_valid,
	input  wire             out_ready,
	output bu_pkg::dp_cmd_t ctl
);
	import bu_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_DIV_INIT,
		S_DIV,
		S_DIV_END,
		S_ADDR,
		S_READ,
		S_PROD,
		S_ACC,
		S_OUT
	} state_t;

	state_t               state_q;
	logic                 axis_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [1:0]           tap_q;
	logic                 out_valid_q;
	logic                 accept;
	logic                 out_load;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		ctl.load = accept;
		ctl.axis = axis_q;
		ctl.tap  = tap_q;
		case (state_q)
			S_MUL:      ctl.op = OP_MUL;
			S_DIV_INIT: ctl.op = OP_DIV_INIT;
			S_DIV:      ctl.op = OP_DIV_STEP;
			S_DIV_END:  ctl.op = OP_DIV_END;
			S_ADDR:     ctl.op = OP_TAP_ADDR;
			S_READ:     ctl.op = OP_TAP_READ;
			S_PROD:     ctl.op = OP_TAP_PROD;
			S_ACC:      ctl.op = OP_TAP_ACC;
			S_OUT:      ctl.op = out_load ? OP_OUT : OP_NONE;
			default:    ctl.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= AXIS_X;
			cnt_q       <= '0;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register frees up in the same cycle it is taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && cmd == CMD_PIXEL) begin
						axis_q  <= AXIS_X;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DIV_INIT;
				end
				S_DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) begin
						state_q <= S_DIV_END;
					end
				end
				S_DIV_END: begin
					if (axis_q == AXIS_X) begin
						axis_q  <= AXIS_Y;
						state_q <= S_MUL;
					end else begin
						tap_q   <= '0;
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_PROD;
				end
				S_PROD: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					tap_q <= tap_q + 1'b1;
					if (tap_q == 2'd3) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_ADDR;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: design/bilinear_upsampler.sv
`default_nettype none

// Bilinear resize with half-pixel centers. A cmd 0 beat writes one source
// sample into the on-chip store at its linear index (row * source_width +
// column); writes beyond the store are dropped. A cmd 1 beat requests one
// output pixel and yields one result beat carrying the blended value and its
// coordinates, and no new beat is taken until it is through: per axis a
// multiply step, a setup step, the shared two-bit-per-cycle divider that
// gives the source position and the 8-bit fraction, and a clamp step; then
// four taps (address, read, product, accumulate) through the single read
// port of the sample store, and a load into the output register. A finished
// result may wait in the output register while the next beat is taken. Reads
// of store entries that were never written return undefined data. Dimension
// registers are to be written by the user only while the block is idle; the
// block itself does not enforce this. A register holding zero acts as one.
module bilinear_upsampler #(
	parameter int MAX_SOURCE_SAMPLES = bu_pkg::DEF_SOURCE_SAMPLES,
	parameter int SAMPLE_BITS        = bu_pkg::DEF_SAMPLE_BITS
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire                             cmd,
	input  wire [bu_pkg::IDX_BITS-1:0]      sample_index,
	input  wire [SAMPLE_BITS-1:0]           sample_value,
	input  wire [bu_pkg::POS_BITS-1:0]      target_x,
	input  wire [bu_pkg::POS_BITS-1:0]      target_y,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [SAMPLE_BITS-1:0]          pixel_value,
	output logic [bu_pkg::POS_BITS-1:0]     pixel_x,
	output logic [bu_pkg::POS_BITS-1:0]     pixel_y,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [bu_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire [bu_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import bu_pkg::*;

	dp_cmd_t ctl;

	assign cfg_ready = 1'b1;

	bu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	bu_datapath #(
		.MAX_SOURCE_SAMPLES (MAX_SOURCE_SAMPLES),
		.SAMPLE_BITS        (SAMPLE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cmd          (cmd),
		.sample_index (sample_index),
		.sample_value (sample_value),
		.target_x     (target_x),
		.target_y     (target_y),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_value  (pixel_value),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y)
	);

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import bu_pkg::*;

	localparam int STORE_DEPTH = DEF_SOURCE_SAMPLES;
	localparam int VALUE_BITS  = DEF_SAMPLE_BITS;
	localparam int SETTLE_CYCLES = 64;
	localparam int STALL_LIMIT = 2000;
	localparam longint unsigned ONE_WEIGHT = 64'd1 << FRAC_BITS;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [POS_BITS-1:0]   x;
		logic [POS_BITS-1:0]   y;
	} pixel_t;

	// the four source positions a request blends, plus the weights
	typedef struct packed {
		logic [IDX_BITS-1:0]  i00;
		logic [IDX_BITS-1:0]  i10;
		logic [IDX_BITS-1:0]  i01;
		logic [IDX_BITS-1:0]  i11;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
	} taps_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     cmd = CMD_WRITE;
	logic [IDX_BITS-1:0]      sample_index = '0;
	logic [VALUE_BITS-1:0]    sample_value = '0;
	logic [POS_BITS-1:0]      target_x = '0;
	logic [POS_BITS-1:0]      target_y = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [VALUE_BITS-1:0]    pixel_value;
	logic [POS_BITS-1:0]      pixel_x;
	logic [POS_BITS-1:0]      pixel_y;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	bilinear_upsampler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.sample_index (sample_index),
		.sample_value (sample_value),
		.target_x     (target_x),
		.target_y     (target_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_value  (pixel_value),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// shadow of the block's state
	logic [VALUE_BITS-1:0]   pixel_store [STORE_DEPTH];
	bit                      written [STORE_DEPTH];
	logic [SRC_DIM_BITS-1:0] src_w = 1;
	logic [SRC_DIM_BITS-1:0] src_h = 1;
	logic [TGT_DIM_BITS-1:0] tgt_w = 1;
	logic [TGT_DIM_BITS-1:0] tgt_h = 1;

	pixel_t pending_pixels[$];
	pixel_t want;
	int     error_count = 0;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	int     recv_hold = 0;
	int     quiet_cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// half-pixel center mapping of one output coordinate onto a source axis
	function automatic void map_axis(input longint unsigned pos, in_n, out_n,
			output longint unsigned base, frac);
		longint unsigned in_len, out_len, num, den, n;
		in_len = (in_n == 0) ? 1 : in_n;
		out_len = (out_n == 0) ? 1 : out_n;
		num = (2 * pos + 1) * in_len;
		den = 2 * out_len;
		if (num <= out_len) begin
			base = 0;
			frac = 0;
		end else begin
			n = num - out_len;
			base = n / den;
			frac = ((n % den) << FRAC_BITS) / den;
		end
		if (base >= in_len - 1) begin
			base = in_len - 1;
			frac = 0;
		end
	endfunction

	function automatic logic [IDX_BITS-1:0] store_addr(input longint unsigned row, col,
			input longint unsigned width);
		longint unsigned lin;
		lin = row * width + col;
		if (lin > STORE_DEPTH - 1)
			lin = STORE_DEPTH - 1;
		return lin[IDX_BITS-1:0];
	endfunction

	function automatic taps_t locate_taps(input logic [POS_BITS-1:0] tx, ty);
		longint unsigned in_w, in_h, x0, x1, y0, y1, fx, fy;
		taps_t t;
		in_w = (src_w == 0) ? 1 : src_w;
		in_h = (src_h == 0) ? 1 : src_h;
		map_axis(tx, in_w, tgt_w, x0, fx);
		map_axis(ty, in_h, tgt_h, y0, fy);
		x1 = (x0 + 1 < in_w) ? x0 + 1 : in_w - 1;
		y1 = (y0 + 1 < in_h) ? y0 + 1 : in_h - 1;
		t.i00 = store_addr(y0, x0, in_w);
		t.i10 = store_addr(y0, x1, in_w);
		t.i01 = store_addr(y1, x0, in_w);
		t.i11 = store_addr(y1, x1, in_w);
		t.fx = fx[FRAC_BITS-1:0];
		t.fy = fy[FRAC_BITS-1:0];
		return t;
	endfunction

	// one input beat; the shadow state moves at the accepting edge
	task automatic send_item(input logic op, input logic [IDX_BITS-1:0] idx,
			input logic [VALUE_BITS-1:0] val, input logic [POS_BITS-1:0] x, y);
		int gap;
		taps_t t;
		longint unsigned wx0, wx1, wy0, wy1, sum;
		pixel_t p;
		gap = 0;
		if (send_idle_pct != 0) begin
			while ($urandom_range(99) < send_idle_pct && gap < 100)
				gap++;
			if ($urandom_range(15) == 0)
				gap += $urandom_range(1, 60);
		end
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= op;
		sample_index <= idx;
		sample_value <= val;
		target_x <= x;
		target_y <= y;
		do @(posedge clk); while (!in_ready);
		if (op == CMD_WRITE) begin
			pixel_store[idx] = val;
			written[idx] = 1'b1;
		end else begin
			t = locate_taps(x, y);
			wx1 = t.fx;
			wy1 = t.fy;
			wx0 = ONE_WEIGHT - wx1;
			wy0 = ONE_WEIGHT - wy1;
			sum = longint'(pixel_store[t.i00]) * (wx0 * wy0)
				+ longint'(pixel_store[t.i10]) * (wx1 * wy0)
				+ longint'(pixel_store[t.i01]) * (wx0 * wy1)
				+ longint'(pixel_store[t.i11]) * (wx1 * wy1);
			sum = sum >> (2 * FRAC_BITS);
			p.value = sum[VALUE_BITS-1:0];
			p.x = x;
			p.y = y;
			pending_pixels = {pending_pixels, p};
		end
	endtask

	// fill any corner that was never written, then ask for the pixel
	task automatic request_pixel(input logic [POS_BITS-1:0] tx, ty);
		taps_t t;
		logic [IDX_BITS-1:0] corner [4];
		t = locate_taps(tx, ty);
		corner[0] = t.i00;
		corner[1] = t.i10;
		corner[2] = t.i01;
		corner[3] = t.i11;
		foreach (corner[k])
			if (!written[corner[k]])
				send_item(CMD_WRITE, corner[k], VALUE_BITS'($urandom),
					POS_BITS'($urandom), POS_BITS'($urandom));
		send_item(CMD_PIXEL, IDX_BITS'($urandom), VALUE_BITS'($urandom), tx, ty);
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SOURCE_WIDTH:  src_w = data;
			REG_SOURCE_HEIGHT: src_h = data;
			REG_TARGET_WIDTH:  tgt_w = data[TGT_DIM_BITS-1:0];
			REG_TARGET_HEIGHT: tgt_h = data[TGT_DIM_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_geometry(input logic [CFG_DATA_BITS-1:0] sw, sh, tw, th);
		hold_until_drained();
		// a trailing sample write may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_SOURCE_WIDTH, sw);
		write_reg(REG_SOURCE_HEIGHT, sh);
		write_reg(REG_TARGET_WIDTH, tw);
		write_reg(REG_TARGET_HEIGHT, th);
	endtask

	task automatic test_reset_geometry();
		send_item(CMD_WRITE, '0, '1, '0, '0);
		request_pixel(0, 0);
		request_pixel('1, '1);
		send_item(CMD_WRITE, '1, '0, '1, '1);
	endtask

	task automatic test_edges_and_interior();
		set_geometry(4, 3, 8, 6);
		request_pixel(0, 0);
		request_pixel(7, 5);
		request_pixel(3, 2);
		request_pixel('1, 0);
		set_geometry(1, 1, 1024, 1024);
		request_pixel(1023, 1023);
	endtask

	task automatic test_zero_registers();
		set_geometry(0, 0, 0, 0);
		request_pixel(5, 9);
	endtask

	task automatic test_store_saturation();
		set_geometry(4096, 4096, 1, 1);
		request_pixel(0, 0);
		set_geometry('1, '1, 2047, 2047);
		request_pixel(0, 0);
		request_pixel('1, '1);
	endtask

	function automatic int pick_source_dim();
		case ($urandom_range(9))
			0: return 1;
			1: return $urandom_range(1, 4096);
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	function automatic int pick_target_dim();
		case ($urandom_range(9))
			0: return 1;
			1: return 1024;
			2: return $urandom_range(1, 1024);
			default: return $urandom_range(1, 256);
		endcase
	endfunction

	task automatic test_random_traffic(input int send_pct, stall_pct, count);
		int seg, k, roll, area, x_lim, y_lim;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		for (seg = 0; seg < 4; seg++) begin
			set_geometry(CFG_DATA_BITS'(pick_source_dim()), CFG_DATA_BITS'(pick_source_dim()),
				CFG_DATA_BITS'(pick_target_dim()), CFG_DATA_BITS'(pick_target_dim()));
			area = ((src_w == 0) ? 1 : src_w) * ((src_h == 0) ? 1 : src_h);
			if (area > STORE_DEPTH)
				area = STORE_DEPTH;
			x_lim = (tgt_w == 0) ? 1 : ((tgt_w > 1024) ? 1024 : tgt_w);
			y_lim = (tgt_h == 0) ? 1 : ((tgt_h > 1024) ? 1024 : tgt_h);
			for (k = 0; k < count / 4; k++) begin
				// let the block run dry once mid segment
				if (k == count / 8)
					hold_until_drained();
				roll = $urandom_range(99);
				if (roll < 35)
					send_item(CMD_WRITE, IDX_BITS'($urandom), VALUE_BITS'($urandom),
						POS_BITS'($urandom), POS_BITS'($urandom));
				else if (roll < 45)
					send_item(CMD_WRITE, IDX_BITS'($urandom_range(0, area - 1)),
						VALUE_BITS'($urandom), POS_BITS'($urandom), POS_BITS'($urandom));
				else if (roll < 92)
					request_pixel(POS_BITS'($urandom_range(0, x_lim - 1)),
						POS_BITS'($urandom_range(0, y_lim - 1)));
				else
					request_pixel(POS_BITS'($urandom), POS_BITS'($urandom));
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// result side back-pressure, with occasional long stalls
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			out_ready <= 1'b0;
		end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
			if ($urandom_range(15) == 0)
				recv_hold <= $urandom_range(1, 60);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$error("result beat with no pixel request pending: x %0d y %0d",
					pixel_x, pixel_y);
				error_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_value !== want.value) begin
					$error("pixel_value: expected %0d, got %0d", want.value, pixel_value);
					error_count++;
				end
				if (pixel_x !== want.x) begin
					$error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
					error_count++;
				end
				if (pixel_y !== want.y) begin
					$error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$error("no beat accepted for %0d cycles", quiet_cycles);
			$display("** bilinear_upsampler: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_geometry();
		test_edges_and_interior();
		test_zero_registers();
		test_store_saturation();
		test_random_traffic(0, 0, 128);
		test_random_traffic(65, 0, 128);
		test_random_traffic(0, 65, 128);
		test_random_traffic(14, 14, 128);
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("** bilinear_upsampler: PASSED **");
		else
			$display("** bilinear_upsampler: FAILED **");
		$finish;
	end

endmodule

// File: files.f
design/bu_pkg.sv
design/bu_datapath.sv
design/bu_ctrl.sv
design/bilinear_upsampler.sv
test/testbench.sv
